// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file of this project.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property that is ignored while reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("checker property failed");

// Clocked property that also holds during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("checker property failed during or after reset");

`endif

// ----- hw/rtl/dpb_pkg.sv -----
// ---------------------------------------------------------------------------
// dpb_pkg
// Types, widths, register codes and reset values of the depth pixel
// back-projection block.
// ---------------------------------------------------------------------------
package dpb_pkg;

    // Field widths.
    localparam int PIX_W       = 12;
    localparam int DEPTH_W     = 16;
    localparam int COORD_W     = 16;
    localparam int CENTER_W    = 16;
    localparam int RECIP_W     = 32;
    localparam int LIMIT_W     = 15;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    // Datapath widths: offset magnitude, offset times depth, full product, fraction and quotient.
    localparam int OFF_W  = CENTER_W;
    localparam int PD_W   = OFF_W + DEPTH_W;
    localparam int MAG_W  = PD_W + RECIP_W;
    localparam int FRAC_W = 36;
    localparam int QUO_W  = MAG_W - FRAC_W;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CENTER_COL      = 3'd0,
        REG_CENTER_ROW      = 3'd1,
        REG_RECIP_FOCAL_COL = 3'd2,
        REG_RECIP_FOCAL_ROW = 3'd3,
        REG_MIN_DEPTH       = 3'd4,
        REG_MAX_DEPTH       = 3'd5,
        REG_LATERAL_LIMIT   = 3'd6
    } cfg_index_t;

    // Reset values of the configuration registers.
    localparam logic [CENTER_W-1:0] RST_CENTER_COL    = 16'd10240;
    localparam logic [CENTER_W-1:0] RST_CENTER_ROW    = 16'd5760;
    localparam logic [RECIP_W-1:0]  RST_RECIP_FOCAL   = 32'd8589934;
    localparam logic [DEPTH_W-1:0]  RST_MIN_DEPTH     = 16'd10;
    localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH     = 16'd5000;
    localparam logic [LIMIT_W-1:0]  RST_LATERAL_LIMIT = 15'd5000;

    // Camera and window settings.
    typedef struct packed {
        logic [CENTER_W-1:0] center_col;
        logic [CENTER_W-1:0] center_row;
        logic [RECIP_W-1:0]  recip_focal_col;
        logic [RECIP_W-1:0]  recip_focal_row;
        logic [DEPTH_W-1:0]  min_depth;
        logic [DEPTH_W-1:0]  max_depth;
        logic [LIMIT_W-1:0]  lateral_limit;
    } cfg_t;

    // Front stage result: range flag, offsets, depth, indexes and grid quotients.
    typedef struct packed {
        logic               in_range;
        logic               neg_x;
        logic [OFF_W-1:0]   off_x;
        logic               neg_y;
        logic [OFF_W-1:0]   off_y;
        logic [DEPTH_W-1:0] depth;
        logic [PIX_W-1:0]   row;
        logic [PIX_W-1:0]   col;
        logic [PIX_W-1:0]   row_q;
        logic [PIX_W-1:0]   col_q;
    } front_t;

    // Scaled products ahead of rounding and clipping.
    typedef struct packed {
        logic               neg_x;
        logic [MAG_W-1:0]   mag_x;
        logic               neg_y;
        logic [MAG_W-1:0]   mag_y;
        logic [DEPTH_W-1:0] depth;
    } prod_t;

endpackage

// ----- hw/rtl/dpb_stream_if.sv -----
// ---------------------------------------------------------------------------
// dpb stream interfaces
// Valid/ready channels for depth pixels in and 3-D points out.
// ---------------------------------------------------------------------------
interface dpb_pixel_if import dpb_pkg::*;;
    logic               valid;
    logic               ready;
    logic [PIX_W-1:0]   pixel_row;
    logic [PIX_W-1:0]   pixel_col;
    logic [DEPTH_W-1:0] depth_mm;

    modport source (output valid, pixel_row, pixel_col, depth_mm, input ready);
    modport sink   (input valid, pixel_row, pixel_col, depth_mm, output ready);
endinterface

interface dpb_point_if import dpb_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;

    modport source (output valid, point_x, point_y, point_z, input ready);
    modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

// ----- hw/rtl/dpb_front.sv -----
// ---------------------------------------------------------------------------
// dpb_front
// First pipeline stage: principal point offsets, depth window, image bounds
// and the quotients used for the sampling grid check.
// ---------------------------------------------------------------------------
module dpb_front import dpb_pkg::*; #(
    parameter int STEP    = 10,
    parameter int MAX_DIM = 4096
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [PIX_W-1:0]   in_row,
    input  logic [PIX_W-1:0]   in_col,
    input  logic [DEPTH_W-1:0] in_depth,
    output logic               out_valid,
    input  logic               out_ready,
    output front_t             out_data
);

    // Division by STEP as a multiply by a rounded-up reciprocal.
    localparam int QSHIFT = PIX_W + 7;
    localparam int MULT_W = QSHIFT + 1;
    localparam int PROD_W = PIX_W + MULT_W;
    localparam logic [MULT_W-1:0] QMULT = MULT_W'(((2 ** QSHIFT) + STEP - 1) / STEP);
    localparam logic [PIX_W:0] DIM_LIMIT = (PIX_W + 1)'(MAX_DIM);

    logic              valid_reg;
    logic              valid_next;
    front_t            data_reg;
    front_t            data_next;
    logic [PROD_W-1:0] row_prod;
    logic [PROD_W-1:0] col_prod;
    logic [OFF_W-1:0]  p16_x;
    logic [OFF_W-1:0]  p16_y;

    // The stage takes a request whenever it is empty or drains this cycle.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // Offsets from the principal point in 1/16 pixel, as sign and magnitude.
    always_comb
    begin
        p16_x = {in_col, 4'b0000};
        p16_y = {in_row, 4'b0000};
        row_prod = PROD_W'(in_row) * PROD_W'(QMULT);
        col_prod = PROD_W'(in_col) * PROD_W'(QMULT);

        data_next.neg_x = p16_x < cfg.center_col;
        data_next.off_x = data_next.neg_x ? (cfg.center_col - p16_x) : (p16_x - cfg.center_col);
        data_next.neg_y = p16_y < cfg.center_row;
        data_next.off_y = data_next.neg_y ? (cfg.center_row - p16_y) : (p16_y - cfg.center_row);
        data_next.depth = in_depth;
        data_next.row   = in_row;
        data_next.col   = in_col;
        data_next.row_q = row_prod[QSHIFT +: PIX_W];
        data_next.col_q = col_prod[QSHIFT +: PIX_W];
        data_next.in_range = ({1'b0, in_row} < DIM_LIMIT) && ({1'b0, in_col} < DIM_LIMIT)
                          && (in_depth >= cfg.min_depth) && (in_depth <= cfg.max_depth);
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload register.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- hw/rtl/dpb_scale.sv -----
// ---------------------------------------------------------------------------
// dpb_scale
// Second and third pipeline stages: grid check with offset times depth,
// then the product with the focal reciprocal.
// ---------------------------------------------------------------------------
module dpb_scale import dpb_pkg::*; #(
    parameter int STEP = 10
) (
    input  logic   clk,
    input  logic   rst_n,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  front_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output prod_t  out_data
);

    localparam int BACK_W = 2 * PIX_W;

    logic               s2_valid_reg;
    logic               s2_valid_next;
    logic               s2_neg_x_reg;
    logic               s2_neg_y_reg;
    logic [PD_W-1:0]    s2_pd_x_reg;
    logic [PD_W-1:0]    s2_pd_y_reg;
    logic [DEPTH_W-1:0] s2_depth_reg;
    logic               s3_valid_reg;
    logic               s3_valid_next;
    prod_t              s3_data_reg;
    logic               s3_ready;
    logic [BACK_W-1:0]  row_back;
    logic [BACK_W-1:0]  col_back;
    logic               keep;

    // A pixel is kept when it is in range and both indexes lie on the grid.
    always_comb
    begin
        row_back = BACK_W'(in_data.row_q) * BACK_W'(STEP);
        col_back = BACK_W'(in_data.col_q) * BACK_W'(STEP);
        keep = in_data.in_range
            && (row_back == BACK_W'(in_data.row))
            && (col_back == BACK_W'(in_data.col));
    end

    // Each stage moves on when it is empty or its successor takes the item.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign in_ready = !s2_valid_reg || s3_ready;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        if (in_ready)
        begin
            s2_valid_next = in_valid && keep;
        end
        s3_valid_next = s3_valid_reg;
        if (s3_ready)
        begin
            s3_valid_next = s2_valid_reg;
        end
    end

    // Valid bits; rejected pixels leave no item behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    // Offset magnitude times depth.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s2_neg_x_reg <= in_data.neg_x;
            s2_neg_y_reg <= in_data.neg_y;
            s2_pd_x_reg  <= PD_W'(in_data.off_x) * PD_W'(in_data.depth);
            s2_pd_y_reg  <= PD_W'(in_data.off_y) * PD_W'(in_data.depth);
            s2_depth_reg <= in_data.depth;
        end
    end

    // Product with the reciprocal focal length, still scaled by 2^36.
    always_ff @(posedge clk)
    begin
        if (s2_valid_reg && s3_ready)
        begin
            s3_data_reg.neg_x <= s2_neg_x_reg;
            s3_data_reg.neg_y <= s2_neg_y_reg;
            s3_data_reg.mag_x <= MAG_W'(s2_pd_x_reg) * MAG_W'(cfg.recip_focal_col);
            s3_data_reg.mag_y <= MAG_W'(s2_pd_y_reg) * MAG_W'(cfg.recip_focal_row);
            s3_data_reg.depth <= s2_depth_reg;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_data  = s3_data_reg;

endmodule

// ----- hw/rtl/dpb_clip.sv -----
// ---------------------------------------------------------------------------
// dpb_clip
// Output stage: floor rounding of the scaled products, lateral limit test
// and the output register.
// ---------------------------------------------------------------------------
module dpb_clip import dpb_pkg::*; (
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  prod_t                     in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [COORD_W-1:0] out_x,
    output logic signed [COORD_W-1:0] out_y,
    output logic [DEPTH_W-1:0]        out_z
);

    logic               valid_reg;
    logic               valid_next;
    logic [COORD_W-1:0] x_reg;
    logic [COORD_W-1:0] y_reg;
    logic [DEPTH_W-1:0] z_reg;
    logic [QUO_W:0]     q_x;
    logic [QUO_W:0]     q_y;
    logic [QUO_W:0]     lim;
    logic               pass;

    // Magnitude after the shift; a negative value with a fraction rounds
    // one step further from zero, which is floor on the signed result.
    always_comb
    begin
        q_x = {1'b0, in_data.mag_x[MAG_W-1:FRAC_W]}
            + (QUO_W + 1)'(in_data.neg_x && (in_data.mag_x[FRAC_W-1:0] != '0));
        q_y = {1'b0, in_data.mag_y[MAG_W-1:FRAC_W]}
            + (QUO_W + 1)'(in_data.neg_y && (in_data.mag_y[FRAC_W-1:0] != '0));
        lim = (QUO_W + 1)'(cfg.lateral_limit);
        pass = (q_x <= lim) && (q_y <= lim);
    end

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid && pass;
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Point register in two's complement.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg <= in_data.neg_x ? COORD_W'(~q_x + 1'b1) : q_x[COORD_W-1:0];
            y_reg <= in_data.neg_y ? COORD_W'(~q_y + 1'b1) : q_y[COORD_W-1:0];
            z_reg <= in_data.depth;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = $signed(x_reg);
    assign out_y     = $signed(y_reg);
    assign out_z     = z_reg;

endmodule

// ----- hw/rtl/depth_pixel_backprojection.sv -----
// The block turns a stream of depth pixels into 3-D points through a pinhole
// camera model. It takes one pixel per clock while the output is not stalled
// and has four register stages; the rate is set by the pipeline, whose two
// multiplier stages (offset times depth, then times the 32-bit focal
// reciprocal) sit in stages of their own. Pixels off the STEP grid, at or
// beyond MAX_DIM, outside the depth window or beyond the lateral limit
// produce no point. Settings are written through the cfg port and should
// only change while no pixel is in flight.
// ---------------------------------------------------------------------------
// depth_pixel_backprojection
// Top level: configuration registers and the three pipeline sections.
// ---------------------------------------------------------------------------
module depth_pixel_backprojection import dpb_pkg::*; #(
    parameter int STEP    = 10,
    parameter int MAX_DIM = 4096
) (
    input  logic                   clk,
    input  logic                   rst_n,
    dpb_pixel_if.sink              pixel,
    dpb_point_if.source            point,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg;
    cfg_t   cfg_next;
    logic   front_valid;
    logic   front_ready;
    front_t front_data;
    logic   scale_valid;
    logic   scale_ready;
    prod_t  scale_data;

    // Register writes; indexes outside the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_CENTER_COL:      cfg_next.center_col      = cfg_data[CENTER_W-1:0];
                REG_CENTER_ROW:      cfg_next.center_row      = cfg_data[CENTER_W-1:0];
                REG_RECIP_FOCAL_COL: cfg_next.recip_focal_col = cfg_data[RECIP_W-1:0];
                REG_RECIP_FOCAL_ROW: cfg_next.recip_focal_row = cfg_data[RECIP_W-1:0];
                REG_MIN_DEPTH:       cfg_next.min_depth       = cfg_data[DEPTH_W-1:0];
                REG_MAX_DEPTH:       cfg_next.max_depth       = cfg_data[DEPTH_W-1:0];
                REG_LATERAL_LIMIT:   cfg_next.lateral_limit   = cfg_data[LIMIT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_col      <= RST_CENTER_COL;
            cfg_reg.center_row      <= RST_CENTER_ROW;
            cfg_reg.recip_focal_col <= RST_RECIP_FOCAL;
            cfg_reg.recip_focal_row <= RST_RECIP_FOCAL;
            cfg_reg.min_depth       <= RST_MIN_DEPTH;
            cfg_reg.max_depth       <= RST_MAX_DEPTH;
            cfg_reg.lateral_limit   <= RST_LATERAL_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Offsets, bounds and grid quotients.
    dpb_front #(
        .STEP    (STEP),
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (pixel.valid),
        .in_ready  (pixel.ready),
        .in_row    (pixel.pixel_row),
        .in_col    (pixel.pixel_col),
        .in_depth  (pixel.depth_mm),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // Grid check and the two multiplies.
    dpb_scale #(
        .STEP (STEP)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (scale_valid),
        .out_ready (scale_ready),
        .out_data  (scale_data)
    );

    // Rounding, lateral limit and output register.
    dpb_clip u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (scale_valid),
        .in_ready  (scale_ready),
        .in_data   (scale_data),
        .out_valid (point.valid),
        .out_ready (point.ready),
        .out_x     (point.point_x),
        .out_y     (point.point_y),
        .out_z     (point.point_z)
    );

endmodule

// ----- hw/rtl/dpb_checker.sv -----
// ---------------------------------------------------------------------------
// dpb_checker
// Port-level properties of the back-projection block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dpb_checker import dpb_pkg::*; (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pixel_ready,
    input logic                      point_valid,
    input logic                      point_ready,
    input logic signed [COORD_W-1:0] point_x,
    input logic signed [COORD_W-1:0] point_y
);

    // A stalled point request stays up until it is taken.
    `CHK_ASSERT(a_point_hold, clk, rst_n, point_valid && !point_ready |=> point_valid)

    // With the output register empty every stage can move, so the input is ready.
    `CHK_ASSERT(a_ready_when_empty, clk, rst_n, !point_valid |-> pixel_ready)

    // The lateral limit keeps both coordinates off the most negative code.
    `CHK_ASSERT(a_coord_range, clk, rst_n, point_valid |-> (point_x != 16'sh8000) && (point_y != 16'sh8000))

    // Reset leaves the point channel empty from the following edge on.
    `CHK_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !point_valid)

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_ready (pixel.ready),
    .point_valid (point.valid),
    .point_ready (point.ready),
    .point_x     (point.point_x),
    .point_y     (point.point_y)
);
